/* rtl/swm_pkg.sv */
// package for the sliding window maximum block
// holds default sizes and register reset values; no dependencies
package swm_pkg;

   // default sizes handed to the top level parameters
   localparam int MAX_WINDOW_DEF  = 16;
   localparam int SAMPLE_BITS_DEF = 16;

   // window size register
   localparam int                CFG_BITS     = 5;
   localparam logic [CFG_BITS-1:0] WINDOW_RESET = 5'd3;

endpackage

/* rtl/swm_req_if.sv */
// request channel of the sliding window maximum block: sample and first flag
// depends on swm_pkg for the default sample width
interface swm_req_if #(
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          first;

   modport source (output valid, output sample, output first, input ready);
   modport sink   (input valid, input sample, input first, output ready);
endinterface

/* rtl/swm_rsp_if.sv */
// response channel of the sliding window maximum block: window maximum
// depends on swm_pkg for the default sample width
interface swm_rsp_if #(
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] window_max;

   modport source (output valid, output window_max, input ready);
   modport sink   (input valid, input window_max, output ready);
endinterface

/* rtl/swm_csr_if.sv */
// register write channel of the sliding window maximum block: window size
// depends on swm_pkg for the register width
interface swm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [swm_pkg::CFG_BITS-1:0]      data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/sliding_window_maximum.sv */
// top level of the sliding window maximum block
// depends on swm_pkg, swm_req_if, swm_rsp_if, swm_csr_if, swm_chain
//
//   channel   dir   payload                      handshake
//   req_chan  in    sample, first                valid / ready
//   rsp_chan  out   window_max                   valid / ready
//   csr_chan  in    window size (5 bits)         valid / ready, always ready
//
// one request per cycle while request ready is high; each window maximum is formed
// from the running maximum cells and registered in the two entry response buffer
// requests with too few samples in their sequence produce no response
// reset clears the fill count, the response buffer and sets the window to 3
// a two entry response buffer keeps requests flowing while a response waits;
// request ready drops only when both entries are full
module sliding_window_maximum #(
   parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
   input logic  clock,
   input logic  reset,
   swm_req_if.sink   req_chan,
   swm_rsp_if.source rsp_chan,
   swm_csr_if.sink   csr_chan
);
   import swm_pkg::*;

   localparam int WW       = $clog2(MAX_WINDOW + 1);
   localparam int SEL_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   logic [CFG_BITS-1:0]           window_size_ff;
   logic [WW-1:0]                 fill_ff;
   logic [WW-1:0]                 fill_in;
   logic [WW-1:0]                 eff_window;
   logic [SEL_BITS-1:0]           tap_index;
   logic signed [SAMPLE_BITS-1:0] tap_max;
   logic signed [SAMPLE_BITS-1:0] result;
   logic                          req_accept;
   logic                          emit;
   logic                          push;
   logic                          pop;
   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_data_ff;
   logic                          skid_valid_ff;
   logic signed [SAMPLE_BITS-1:0] skid_data_ff;

   // window size register
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         window_size_ff <= csr_chan.data;
      end
   end

   // effective window: zero means one, clamp to the chain length
   always_comb begin
      if (window_size_ff == '0) begin
         eff_window = WW'(1);
      end else if (32'(window_size_ff) > MAX_WINDOW) begin
         eff_window = WW'(MAX_WINDOW);
      end else begin
         eff_window = WW'(window_size_ff);
      end
   end

   assign tap_index = (eff_window >= WW'(2)) ? SEL_BITS'(eff_window - WW'(2)) : '0;

   // request handshake
   assign req_chan.ready = !skid_valid_ff;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // fill count of the current sequence, saturating at the chain length
   always_comb begin
      if (req_chan.first) begin
         fill_in = WW'(1);
      end else if (32'(fill_ff) < MAX_WINDOW) begin
         fill_in = fill_ff + WW'(1);
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (req_accept) begin
         fill_ff <= fill_in;
      end
   end

   // running maximum cells
   swm_chain #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_chain (
      .clock     (clock),
      .shift     (req_accept),
      .sample    (req_chan.sample),
      .tap_index (tap_index),
      .tap_max   (tap_max)
   );

   // window maximum of the incoming request
   assign result = ((eff_window == WW'(1)) || (tap_max < req_chan.sample))
                   ? req_chan.sample : tap_max;
   assign emit   = (fill_in >= eff_window);
   assign push   = req_accept && emit;
   assign pop    = out_valid_ff && rsp_chan.ready;

   // two entry response buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : result;
      end else if (push) begin
         if (out_valid_ff) begin
            skid_data_ff <= result;
         end else begin
            out_data_ff <= result;
         end
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.window_max = out_data_ff;

   // checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_first_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_chan.first) |=> (fill_ff == WW'(1)))
      else $error("first request did not restart the fill count");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= MAX_WINDOW)
      else $error("fill count beyond the chain length");

   a_buffer_idle: assert property (@(posedge clock) disable iff (reset)
      (!push && !pop) |=> ($stable(out_valid_ff) && $stable(skid_valid_ff)))
      else $error("response buffer changed without push or pop");

endmodule

/* rtl/swm_cell.sv */
// one cell of the running maximum chain: max of the newest sample and the
// neighbor's previous maximum; no package dependencies
module swm_cell #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          shift,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] carry_in,
   output logic signed [SAMPLE_BITS-1:0] carry_out
);

   logic signed [SAMPLE_BITS-1:0] max_ff;
   logic signed [SAMPLE_BITS-1:0] max_in;

   // max over one more sample than the neighbor held
   assign max_in = (carry_in > sample) ? carry_in : sample;

   always_ff @(posedge clock) begin
      if (shift) begin
         max_ff <= max_in;
      end
   end

   assign carry_out = max_ff;

endmodule

/* rtl/swm_chain.sv */
// row of running maximum cells; cell k holds the max of the last k+1 samples
// depends on swm_cell
module swm_chain #(
   parameter int MAX_WINDOW  = 16,
   parameter int SAMPLE_BITS = 16,
   localparam int SEL_BITS   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
   input  logic                          clock,
   input  logic                          shift,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic        [SEL_BITS-1:0]    tap_index,
   output logic signed [SAMPLE_BITS-1:0] tap_max
);

   logic signed [SAMPLE_BITS-1:0] carry [MAX_WINDOW];

   // cell zero sees the sample on both sides, so it simply takes it
   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      swm_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock     (clock),
         .shift     (shift),
         .sample    (sample),
         .carry_in  ((k == 0) ? sample : carry[(k == 0) ? 0 : k - 1]),
         .carry_out (carry[k])
      );
   end

   // tap of the cell that covers all but the newest sample of the window
   always_comb begin
      tap_max = carry[0];
      for (int k = 0; k < MAX_WINDOW; k++) begin
         if (tap_index == SEL_BITS'(k)) begin
            tap_max = carry[k];
         end
      end
   end

endmodule

/* test/sliding_window_maximum_tb.sv */
`timescale 1ns / 1ps
// testbench for sliding_window_maximum: directed, random and backpressure requests
// checked against an in-bench window maximum tracker
// depends on swm_pkg, the channel interfaces and sliding_window_maximum
module sliding_window_maximum_tb;
   import swm_pkg::*;

   localparam int MAX_W       = MAX_WINDOW_DEF;
   localparam int SBITS       = SAMPLE_BITS_DEF;
   localparam int PIPE_PAD    = 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   typedef logic signed [SBITS-1:0] sample_type;

   logic clock = 1'b0;
   logic reset;

   swm_req_if req_if ();
   swm_rsp_if rsp_if ();
   swm_csr_if csr_if ();

   sliding_window_maximum u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // tracker state: window register, sample history, fill level, write slot
   logic [CFG_BITS-1:0] window_size_reg;
   sample_type          sample_history [MAX_W];
   int                  fill_level;
   int                  write_slot;
   sample_type          pending_max [$];

   int   mismatches = 0;
   int   cycle_count = 0;
   logic req_gaps_on;
   logic rsp_gaps_on;
   logic rsp_hold;

   always #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int draw_gap(input logic on);
      if (!on) return 0;
      return int'($urandom_range(0, 14));
   endfunction

   // mostly random values, with the extremes and values near zero mixed in
   function automatic sample_type pick_sample();
      case ($urandom_range(0, 7))
         0: return sample_type'(-32768);
         1: return sample_type'(32767);
         2: return sample_type'($signed($urandom_range(0, 8)) - 4);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // expected maximum over the last window_size samples of the sequence
   function automatic void track_window_max(input sample_type s, input logic f);
      int         span;
      int         slot;
      sample_type best;
      if (f) fill_level = 0;
      sample_history[write_slot] = s;
      write_slot = (write_slot + 1) % MAX_W;
      if (fill_level < MAX_W) fill_level++;
      if (window_size_reg == 0) span = 1;
      else if (int'(window_size_reg) > MAX_W) span = MAX_W;
      else span = int'(window_size_reg);
      if (fill_level < span) return;
      slot = (write_slot + MAX_W - 1) % MAX_W;
      best = sample_history[slot];
      for (int k = 1; k < span; k++) begin
         slot = (slot + MAX_W - 1) % MAX_W;
         if (sample_history[slot] > best) best = sample_history[slot];
      end
      pending_max.insert(pending_max.size(), best);
   endfunction

   // response side: random stalls, long hold when asked, compare each response
   initial begin : rsp_side
      int         stall_left;
      sample_type want;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_max.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, got %0d",
                        $time, rsp_if.window_max);
            end else begin
               want = pending_max.pop_front();
               if (rsp_if.window_max !== want) begin
                  mismatches++;
                  $display("%0t: window_max mismatch, expected %0d, got %0d",
                           $time, want, rsp_if.window_max);
               end
            end
            stall_left = draw_gap(rsp_gaps_on);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_if.ready <= (stall_left == 0) && !rsp_hold;
      end
   end

   // send one request; valid stays high across back to back requests
   task automatic send_sample(input sample_type s, input logic f);
      int gap;
      gap = draw_gap(req_gaps_on);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= s;
      req_if.first  <= f;
      do @(posedge clock); while (!req_if.ready);
      track_window_max(s, f);
   endtask

   // drop valid, drain all responses, let the pipeline settle
   task automatic finish_phase();
      req_if.valid <= 1'b0;
      while (pending_max.size() != 0) @(posedge clock);
      repeat (PIPE_PAD) @(posedge clock);
   endtask

   task automatic write_window(input logic [CFG_BITS-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      window_size_reg = value;
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_sequence(input int len, input logic fresh);
      for (int i = 0; i < len; i++) send_sample(pick_sample(), fresh && (i == 0));
   endtask

   // window of 3 from reset: no first flag at start, short sequences, extremes
   task automatic test_directed();
      send_sample(sample_type'(32767), 1'b0);
      send_sample(sample_type'(-32768), 1'b0);
      send_sample(sample_type'(-1), 1'b0);
      send_sample(sample_type'(0), 1'b0);
      send_sample(sample_type'(16'h5555), 1'b1);
      send_sample(sample_type'(-32768), 1'b1);
      send_sample(sample_type'(-32768), 1'b0);
      send_sample(sample_type'(-32768), 1'b1);
      send_sample(sample_type'(-32767), 1'b0);
      send_sample(sample_type'(-32768), 1'b0);
      send_sample(sample_type'(16'hAAAA), 1'b0);
      send_sample(sample_type'(32767), 1'b0);
      send_sample(sample_type'(1), 1'b0);
      send_sample(sample_type'(-1), 1'b0);
      send_sample(sample_type'(-32768), 1'b0);
      send_sample(sample_type'(-32768), 1'b0);
      send_sample(sample_type'(-32768), 1'b0);
      send_sample(sample_type'(0), 1'b1);
      send_sample(sample_type'(32767), 1'b1);
      send_sample(sample_type'(32767), 1'b0);
      finish_phase();
   endtask

   // one, zero, the cap, above the cap, the widest code, two and the reset size
   task automatic test_window_extremes();
      logic [CFG_BITS-1:0] sizes [7];
      sizes = '{5'd1, 5'd0, 5'd16, 5'd17, 5'd31, 5'd2, WINDOW_RESET};
      foreach (sizes[i]) begin
         write_window(sizes[i]);
         send_sequence(24, 1'b1);
         send_sequence(5, 1'b1);
         finish_phase();
      end
   endtask

   // new window applies to the running sequence from the next request on
   task automatic test_resize_midsequence();
      write_window(5'd2);
      send_sequence(10, 1'b1);
      finish_phase();
      write_window(5'd12);
      send_sequence(6, 1'b0);
      finish_phase();
      write_window(5'd1);
      send_sequence(5, 1'b0);
      finish_phase();
      write_window(5'd16);
      send_sequence(20, 1'b0);
      finish_phase();
   endtask

   // random sequences with random window settings and idling patterns
   task automatic test_random_stream(input int total);
      int sent;
      int len;
      sent = 0;
      while (sent < total) begin
         if ($urandom_range(0, 3) == 0) write_window(5'($urandom_range(0, 31)));
         else write_window(5'($urandom_range(1, 6)));
         req_gaps_on <= ($urandom_range(0, 2) != 0);
         rsp_gaps_on <= ($urandom_range(0, 2) != 0);
         for (int n = 0; n < 150 && sent < total; n += len) begin
            // mostly fresh sequences, sometimes a continuation or a tiny burst
            if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 3);
            else len = $urandom_range(4, 40);
            send_sequence(len, $urandom_range(0, 7) != 0);
            sent += len;
         end
         finish_phase();
      end
   endtask

   // long receiver hold while requests keep coming, so the block stalls its input
   task automatic test_backpressure();
      write_window(5'd1);
      req_gaps_on <= 1'b0;
      rsp_gaps_on <= 1'b0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         send_sequence(60, 1'b1);
      join
      finish_phase();
   endtask

   initial begin
      reset         <= 1'b1;
      req_if.valid  <= 1'b0;
      req_if.sample <= '0;
      req_if.first  <= 1'b0;
      csr_if.valid  <= 1'b0;
      csr_if.data   <= '0;
      req_gaps_on   <= 1'b0;
      rsp_gaps_on   <= 1'b0;
      rsp_hold      <= 1'b0;
      window_size_reg = WINDOW_RESET;
      fill_level      = 0;
      write_slot      = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      req_gaps_on <= 1'b1;
      rsp_gaps_on <= 1'b1;
      test_window_extremes();
      test_resize_midsequence();
      test_backpressure();
      test_random_stream(880);

      // catch any late or stray responses
      repeat (20) @(posedge clock);
      if (pending_max.size() != 0) begin
         mismatches++;
         $display("%0t: missing response, expected %0d, got none",
                  $time, pending_max[0]);
      end
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/swm_pkg.sv
rtl/swm_req_if.sv
rtl/swm_rsp_if.sv
rtl/swm_csr_if.sv
rtl/swm_cell.sv
rtl/swm_chain.sv
rtl/sliding_window_maximum.sv
test/sliding_window_maximum_tb.sv
